[src/pwc_pkg.sv]
`default_nettype none

package pwc_pkg;

    localparam int unsigned CYCLES_W  = 10;
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned TIMEOUT_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLES_PER_US = 2'd0,
        CFG_WAIT_LEVEL    = 2'd1,
        CFG_MAX_PULSES    = 2'd2,
        CFG_TIMEOUT_US    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_WAIT    = 3'b010,
        PH_CAPTURE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   wait_level;
        logic [COUNT_W-1:0]   max_pulses;
        logic [TIMEOUT_W-1:0] timeout_us;
    } capture_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pulse_index;
        logic               has_duration;
        logic               last;
        logic               timed_out;
        logic [COUNT_W-1:0] captured_count;
    } result_info_t;

endpackage

`default_nettype wire

[src/pwc_timebase.sv]
`default_nettype none

module pwc_timebase #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [pwc_pkg::CYCLES_W-1:0]  cycles_per_us,
    output logic      [TIME_WIDTH-1:0]         micro_time
);
    import pwc_pkg::*;

    logic [CYCLES_W-1:0]   prescale_reg;
    logic [CYCLES_W-1:0]   prescale_next;
    logic [TIME_WIDTH-1:0] micro_reg;
    logic [TIME_WIDTH-1:0] micro_next;
    logic [CYCLES_W:0]     prescale_inc;
    logic                  wrap;

    // wraps also when the count sits above a freshly written divide value
    assign prescale_inc = {1'b0, prescale_reg} + {{CYCLES_W{1'b0}}, 1'b1};
    assign wrap         = prescale_inc >= {1'b0, cycles_per_us};

    always_comb
    begin
        prescale_next = prescale_reg;
        micro_next    = micro_reg;
        if (step)
        begin
            if (wrap)
            begin
                prescale_next = '0;
                micro_next    = micro_reg + TIME_WIDTH'(1);
            end
            else
            begin
                prescale_next = prescale_inc[CYCLES_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            micro_reg    <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            micro_reg    <= micro_next;
        end
    end

    assign micro_time = micro_reg;

endmodule

`default_nettype wire

[src/pwc_capture.sv]
`default_nettype none

module pwc_capture #(
    parameter int unsigned TIME_WIDTH     = 32,
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          start_req,
    input  wire logic                          pin_level,
    input  wire logic [TIME_WIDTH-1:0]         now,
    input  wire pwc_pkg::capture_cfg_t         cfg,
    output logic                               res_valid,
    output pwc_pkg::result_info_t              res_info,
    output logic      [DURATION_WIDTH-1:0]     res_duration
);
    import pwc_pkg::*;

    localparam int unsigned CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;
    localparam int unsigned SAT_W = (TIME_WIDTH > DURATION_WIDTH) ? TIME_WIDTH
                                                                  : DURATION_WIDTH;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIME_WIDTH-1:0] phase_start_reg;
    logic [TIME_WIDTH-1:0] phase_start_next;
    logic [TIME_WIDTH-1:0] last_edge_reg;
    logic [TIME_WIDTH-1:0] last_edge_next;
    logic                  prev_level_reg;
    logic                  prev_level_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    logic [TIME_WIDTH-1:0] phase_elapsed;
    logic [TIME_WIDTH-1:0] edge_elapsed;
    logic                  expired;
    logic                  saturate;
    logic [DURATION_WIDTH-1:0] duration;
    logic                  wait_enabled;
    logic                  level_match;
    logic [COUNT_W-1:0]    limit;
    logic [COUNT_W-1:0]    count_inc;

    assign phase_elapsed = now - phase_start_reg;
    assign edge_elapsed  = now - last_edge_reg;
    assign expired       = CMP_W'(phase_elapsed) > CMP_W'(cfg.timeout_us);
    assign saturate      = SAT_W'(edge_elapsed) > SAT_W'({DURATION_WIDTH{1'b1}});
    assign duration      = saturate ? {DURATION_WIDTH{1'b1}}
                                    : DURATION_WIDTH'(edge_elapsed);
    assign wait_enabled  = !cfg.wait_level[1];
    assign level_match   = wait_enabled && (pin_level == cfg.wait_level[0]);
    assign limit         = (cfg.max_pulses == '0) ? COUNT_W'(1) : cfg.max_pulses;
    assign count_inc     = count_reg + COUNT_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        last_edge_next   = last_edge_reg;
        prev_level_next  = prev_level_reg;
        count_next       = count_reg;
        res_valid        = 1'b0;
        res_info         = '0;
        res_duration     = '0;

        if (start_req)
        begin
            phase_start_next = now;
            count_next       = '0;
            if (wait_enabled && !level_match)
            begin
                phase_next = PH_WAIT;
            end
            else
            begin
                phase_next      = PH_CAPTURE;
                prev_level_next = pin_level;
                last_edge_next  = now;
            end
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (level_match)
                    begin
                        phase_next       = PH_CAPTURE;
                        prev_level_next  = pin_level;
                        phase_start_next = now;
                        last_edge_next   = now;
                        count_next       = '0;
                    end
                    else if (expired)
                    begin
                        phase_next         = PH_IDLE;
                        res_valid          = 1'b1;
                        res_info.last      = 1'b1;
                        res_info.timed_out = 1'b1;
                    end
                end
                PH_CAPTURE:
                begin
                    if (pin_level != prev_level_reg)
                    begin
                        count_next              = count_inc;
                        prev_level_next         = pin_level;
                        last_edge_next          = now;
                        res_valid               = 1'b1;
                        res_duration            = duration;
                        res_info.pulse_index    = count_reg;
                        res_info.has_duration   = 1'b1;
                        res_info.last           = count_inc >= limit;
                        res_info.captured_count = count_inc;
                        if (count_inc >= limit)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (expired)
                    begin
                        phase_next              = PH_IDLE;
                        res_valid               = 1'b1;
                        res_info.last           = 1'b1;
                        res_info.timed_out      = 1'b1;
                        res_info.captured_count = count_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_start_reg <= '0;
            last_edge_reg   <= '0;
            prev_level_reg  <= 1'b0;
            count_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
            last_edge_reg   <= last_edge_next;
            prev_level_reg  <= prev_level_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

[src/pulse_width_capture_core.sv]
`default_nettype none

// Pulse width capture core. Every accepted request is one sample tick of the
// monitored pin together with a start strobe; a free-running prescaler,
// advanced once per request, divides ticks by cycles_per_us into a
// TIME_WIDTH-bit microsecond counter. A start strobe arms a capture that
// optionally waits for wait_level, then reports the length of every level
// that ends at an edge, saturated to DURATION_WIDTH bits, until max_pulses
// lengths are taken. If a phase runs longer than timeout_us microseconds
// from its start, the next tick with no edge or awaited level ends the
// capture with one result flagged timed_out and carrying the count so far.
// A new start drops any capture in progress. Rate: one request per clock,
// sustained while the output is not stalled. The accepting edge loads the
// input register; the capture engine (a TIME_WIDTH-bit subtract and timeout
// compare feeding the phase state) then loads the result register once that
// register is free. Requests that yield no result still pass through and
// advance the time base. Write the configuration registers only while the
// core is idle.
module pulse_width_capture_core #(
    parameter int unsigned TIME_WIDTH     = 32,
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwc_pkg::CFG_DATA_W-1:0] cfg_data,

    // input request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           start_req,
    input  wire logic                           pin_level,

    // result request channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [DURATION_WIDTH-1:0]      duration_us,
    output logic      [pwc_pkg::COUNT_W-1:0]    pulse_index,
    output logic                                has_duration,
    output logic                                last,
    output logic                                timed_out,
    output logic      [pwc_pkg::COUNT_W-1:0]    captured_count
);
    import pwc_pkg::*;

    // configuration registers
    logic [CYCLES_W-1:0] cycles_reg;
    capture_cfg_t        cfg_reg;

    // input register
    logic in_valid_reg;
    logic in_valid_next;
    logic start_reg;
    logic level_reg;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_info_t              info_reg;
    logic [DURATION_WIDTH-1:0] duration_reg;

    logic                      out_free;
    logic                      step;
    logic                      in_take;
    logic [TIME_WIDTH-1:0]     micro_time;
    logic                      res_valid;
    result_info_t              res_info;
    logic [DURATION_WIDTH-1:0] res_duration;

    // The result register frees up when empty or when its request leaves
    // this cycle; the buffered sample steps the engine only then, so the
    // engine state never runs ahead of a stalled result.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg         <= CYCLES_W'(96);
            cfg_reg.wait_level <= LEVEL_W'(2);
            cfg_reg.max_pulses <= COUNT_W'(1);
            cfg_reg.timeout_us <= TIMEOUT_W'(1000000);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CYCLES_PER_US: cycles_reg         <= cfg_data[CYCLES_W-1:0];
                CFG_WAIT_LEVEL:    cfg_reg.wait_level <= cfg_data[LEVEL_W-1:0];
                CFG_MAX_PULSES:    cfg_reg.max_pulses <= cfg_data[COUNT_W-1:0];
                CFG_TIMEOUT_US:    cfg_reg.timeout_us <= cfg_data[TIMEOUT_W-1:0];
                default:           cycles_reg         <= cycles_reg;
            endcase
        end
    end

    // Hold the sample while the result side is stalled; load a new one
    // whenever the register empties or moves on.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            start_reg <= start_req;
            level_reg <= pin_level;
        end
    end

    pwc_timebase #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_timebase (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cycles_per_us (cycles_reg),
        .micro_time    (micro_time)
    );

    pwc_capture #(
        .TIME_WIDTH     (TIME_WIDTH),
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .start_req    (start_reg),
        .pin_level    (level_reg),
        .now          (micro_time),
        .cfg          (cfg_reg),
        .res_valid    (res_valid),
        .res_info     (res_info),
        .res_duration (res_duration)
    );

    // Drop the result once taken; a stepping sample replaces it with its
    // own result or leaves the register empty.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            info_reg     <= res_info;
            duration_reg <= res_duration;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duration_us    = duration_reg;
    assign pulse_index    = info_reg.pulse_index;
    assign has_duration   = info_reg.has_duration;
    assign last           = info_reg.last;
    assign timed_out      = info_reg.timed_out;
    assign captured_count = info_reg.captured_count;

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    import pwc_pkg::*;

    localparam int unsigned DUR_W        = 16;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned REPORT_LIMIT = 10;

    // One result request as the core presents it, fields in port order.
    typedef struct packed {
        logic [DUR_W-1:0]   duration_us;
        logic [COUNT_W-1:0] pulse_index;
        logic               has_duration;
        logic               last;
        logic               timed_out;
        logic [COUNT_W-1:0] captured_count;
    } capture_result_t;

    // Tracks the capture engine tick by tick and holds the results it owes.
    class capture_scoreboard;
        logic [CYCLES_W-1:0]  cycles_per_us;
        logic [LEVEL_W-1:0]   wait_level;
        logic [COUNT_W-1:0]   max_pulses;
        logic [TIMEOUT_W-1:0] timeout_us;

        phase_t               phase;
        logic [CYCLES_W-1:0]  prescale;
        logic [31:0]          now_us;
        logic [31:0]          phase_start;
        logic [31:0]          last_edge;
        logic                 prev_level;
        logic [COUNT_W-1:0]   pulse_count;

        capture_result_t      owed_results[$];
        int unsigned          results_checked;
        int unsigned          mismatches;
        int unsigned          timeouts_seen;
        int unsigned          saturated_seen;

        function new();
            cycles_per_us   = 10'd96;
            wait_level      = 2'd2;
            max_pulses      = 8'd1;
            timeout_us      = 32'd1000000;
            phase           = PH_IDLE;
            prescale        = '0;
            now_us          = '0;
            phase_start     = '0;
            last_edge       = '0;
            prev_level      = 1'b0;
            pulse_count     = '0;
            results_checked = 0;
            mismatches      = 0;
            timeouts_seen   = 0;
            saturated_seen  = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CYCLES_PER_US: cycles_per_us = data[CYCLES_W-1:0];
                CFG_WAIT_LEVEL:    wait_level    = data[LEVEL_W-1:0];
                CFG_MAX_PULSES:    max_pulses    = data[COUNT_W-1:0];
                CFG_TIMEOUT_US:    timeout_us    = data[TIMEOUT_W-1:0];
                default:           ;
            endcase
        endfunction

        function void open_capture(logic level);
            phase       = PH_CAPTURE;
            prev_level  = level;
            phase_start = now_us;
            last_edge   = now_us;
            pulse_count = '0;
        endfunction

        function void note_request(logic start, logic level);
            logic [31:0]        span_us;
            logic [COUNT_W-1:0] limit;
            capture_result_t    r;
            r       = '0;
            span_us = now_us - phase_start;
            if (start) begin
                if (wait_level < 2'd2 && {1'b0, level} != wait_level) begin
                    phase       = PH_WAIT;
                    phase_start = now_us;
                    pulse_count = '0;
                end else begin
                    open_capture(level);
                end
            end else if (phase == PH_WAIT) begin
                if ({1'b0, level} == wait_level) begin
                    open_capture(level);
                end else if (span_us > timeout_us) begin
                    r.last      = 1'b1;
                    r.timed_out = 1'b1;
                    owed_results.push_back(r);
                    phase = PH_IDLE;
                end
            end else if (phase == PH_CAPTURE) begin
                if (level != prev_level) begin
                    span_us          = now_us - last_edge;
                    limit            = (max_pulses == '0) ? 8'd1 : max_pulses;
                    r.duration_us    = (span_us > 32'hFFFF) ? 16'hFFFF : span_us[DUR_W-1:0];
                    r.pulse_index    = pulse_count;
                    r.has_duration   = 1'b1;
                    pulse_count      = pulse_count + 1'b1;
                    prev_level       = level;
                    last_edge        = now_us;
                    r.captured_count = pulse_count;
                    r.last           = (pulse_count >= limit);
                    owed_results.push_back(r);
                    if (r.last)
                        phase = PH_IDLE;
                end else if (span_us > timeout_us) begin
                    r.last           = 1'b1;
                    r.timed_out      = 1'b1;
                    r.captured_count = pulse_count;
                    owed_results.push_back(r);
                    phase = PH_IDLE;
                end
            end

            // The prescaler runs on every tick, whatever the phase.
            if (int'(prescale) + 1 >= int'(cycles_per_us)) begin
                prescale = '0;
                now_us   = now_us + 1;
            end else begin
                prescale = prescale + 1'b1;
            end
        endfunction

        function string describe(capture_result_t r);
            return $sformatf("dur=%0d idx=%0d has=%0b last=%0b tmo=%0b cnt=%0d",
                             r.duration_us, r.pulse_index, r.has_duration, r.last,
                             r.timed_out, r.captured_count);
        endfunction

        function void check_result(capture_result_t got);
            capture_result_t want;
            bit              bad;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result at %0t: %s", $realtime, describe(got));
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            bad = (got.duration_us    !== want.duration_us)  ||
                  (got.pulse_index    !== want.pulse_index)  ||
                  (got.has_duration   !== want.has_duration) ||
                  (got.last           !== want.last)         ||
                  (got.timed_out      !== want.timed_out)    ||
                  (got.captured_count !== want.captured_count);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: expected %s", $realtime, describe(want));
                    $display("                 actual   %s", describe(got));
                end
            end else begin
                if (want.timed_out)
                    timeouts_seen++;
                if (want.has_duration && want.duration_us == 16'hFFFF)
                    saturated_seen++;
            end
        endfunction

        function int unsigned owed_count();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals; every input of the core starts at a known value.
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  start_req = 1'b0;
    logic                  pin_level = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DUR_W-1:0]      duration_us;
    logic [COUNT_W-1:0]    pulse_index;
    logic                  has_duration;
    logic                  last;
    logic                  timed_out;
    logic [COUNT_W-1:0]    captured_count;

    capture_scoreboard board = new();

    bit          gaps_on      = 1'b1;   // random idling on both channels
    bit          hold_request = 1'b0;   // ask the receiver for one long hold-off
    int unsigned ticks_sent   = 0;
    int unsigned reg_writes   = 0;

    pulse_width_capture_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_req      (start_req),
        .pin_level      (pin_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duration_us    (duration_us),
        .pulse_index    (pulse_index),
        .has_duration   (has_duration),
        .last           (last),
        .timed_out      (timed_out),
        .captured_count (captured_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one tick request and hold it until the core takes it. Every call
    // resumes right after a rising edge, so each input gets one update per edge.
    task automatic send_tick(input logic start, input logic level);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= start;
        pin_level <= level;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(start, level);
        ticks_sent++;
    endtask

    // Drop the input, wait for every owed result, then let the pipe drain
    // of ticks that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.owed_count() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers once the core is idle. The narrow registers
    // sometimes get noise above their width, which the core must ignore.
    task automatic set_config(input logic [31:0] cycles, input logic [31:0] level,
                              input logic [31:0] pulses, input logic [31:0] timeout);
        logic [CFG_DATA_W-1:0] value [4];
        int unsigned           width [3];
        int                    i;
        value[0] = cycles;
        value[1] = level;
        value[2] = pulses;
        value[3] = timeout;
        width[0] = CYCLES_W;
        width[1] = LEVEL_W;
        width[2] = COUNT_W;
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 3) == 0)
                value[i] = value[i] | ($urandom() & (32'hFFFF_FFFF << width[i]));
        settle();
        for (i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= value[i];
            @(posedge clk);
            board.write_register(cfg_index_t'(i), value[i]);
            reg_writes++;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed captures: a start, then a train of level runs, at
    // times a long quiet level to run into the timeout. A few noise ticks
    // with random strobe and level are mixed in.
    task automatic run_train_phase(input int unsigned n_items, input int unsigned run_max);
        int unsigned sent;
        int unsigned runs;
        int unsigned len;
        int unsigned r;
        logic        lvl;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 19) == 0) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                lvl = 1'($urandom_range(0, 1));
                send_tick(1'b1, lvl);
                sent++;
                runs = $urandom_range(1, 8);
                for (r = 0; r < runs; r++) begin
                    len = $urandom_range(1, run_max);
                    repeat (len) send_tick(1'b0, lvl);
                    sent += len;
                    lvl = ~lvl;
                end
                if ($urandom_range(0, 2) == 0) begin
                    len = $urandom_range(1, 4 * run_max);
                    repeat (len) send_tick(1'b0, lvl);
                    sent += len;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request so that
    // results pile up and the core has to stall its input.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Check every result the core hands over, against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(capture_result_t'({duration_us, pulse_index, has_duration,
                                                  last, timed_out, captured_count}));
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                 STALL_LIMIT, board.owed_count());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset settings first: no wait, one pulse, a zero
        // length edge right after start.
        gaps_on = 1'b1;
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // Two lengths, then a restart that drops the capture, then a capture
        // timeout with nothing captured, then an idle tick that does nothing.
        set_config(1, 2, 3, 5);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (7) send_tick(1'b0, 1'b1);

        // Zero timeout: wait times out on the first elapsed microsecond,
        // and so does a capture with no edge.
        set_config(1, 1, 2, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);

        // Wait for low: the level arrives just as the timeout expires and
        // wins; an edge likewise wins over the capture timeout.
        set_config(1, 0, 2, 0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Random part over a spread of settings, extremes included. Some
        // phases run without any idling on either side.
        gaps_on = 1'b0;
        set_config(1, 2, 3, 10);          run_train_phase(50, 6);
        gaps_on = 1'b1;
        set_config(2, 0, 5, 4);           run_train_phase(50, 6);
        set_config(1, 1, 255, 30);        run_train_phase(50, 5);
        set_config(0, 3, 0, 0);           run_train_phase(50, 3);
        gaps_on = 1'b0;
        set_config(3, 0, 1, 1);           run_train_phase(50, 8);
        gaps_on = 1'b1;
        set_config(1023, 1, 255, 0);      run_train_phase(50, 12);
        // A small divide value right after the largest one: the prescaler
        // sits above it and must wrap.
        for (i = 0; i < 3; i++) begin
            set_config($urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(1, 8),
                       $urandom_range(0, 40));
            run_train_phase(50, 6);
        end
        set_config(1, 2, 8, 32'hFFFF_FFFF); run_train_phase(50, 10);

        // Back-pressure: a result on every tick after the start while the receiver holds off.
        gaps_on = 1'b0;
        set_config(1, 2, 255, 32'hFFFF_FFFF);
        hold_request = 1'b1;
        send_tick(1'b1, 1'b0);
        for (i = 0; i < 100; i++)
            send_tick(1'b0, 1'(i % 2 == 0));

        settle();
        $display("run covered %0d tick requests and %0d register writes", ticks_sent, reg_writes);
        $display("%0d results checked: %0d timeouts, %0d saturated lengths, %0d mismatches",
                 board.results_checked, board.timeouts_seen, board.saturated_seen,
                 board.mismatches);
        if (board.mismatches == 0 && board.owed_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/pwc_pkg.sv
src/pwc_timebase.sv
src/pwc_capture.sv
src/pulse_width_capture_core.sv
tb/tb.sv
